// File: rtl/core/midi_note_off_scheduler_assert.svh
// Assertion macros shared by the note-off scheduler RTL.
`ifndef MIDI_NOTE_OFF_SCHEDULER_ASSERT_SVH
`define MIDI_NOTE_OFF_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MNOS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MNOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mnos_pkg.sv
// Types and constants of the MIDI note-off scheduler.
`default_nettype none
package mnos_pkg;

    localparam logic [1:0] CMD_TRIGGER = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [3:0] CODE_NOTE_OFF = 4'd8;
    localparam logic [3:0] CODE_NOTE_ON  = 4'd9;

    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;

    localparam int         MS_W      = 32;
    localparam int         SCALE_W   = 10;
    localparam int         PROD_W    = MS_W + SCALE_W;
    localparam logic [SCALE_W-1:0] US_PER_MS = SCALE_W'(1000);

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [7:0]  transport;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [63:0] due_us;
    } slot_t;

    typedef struct packed {
        logic [7:0] transport;
        logic [3:0] code;
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] velocity;
        logic       accepted;
    } msg_t;

endpackage
`default_nettype wire

// File: rtl/core/midi_note_off_scheduler.sv
// Top level of the MIDI note-off scheduler.
//
// Requests arrive on the cmd channel (cmd_valid, cmd_stall) and messages
// leave on the msg channel (msg_valid, msg_stall) through an output register.
// A trigger request emits one note-on after the duration multiply, the off
// time sum in the shared 64-bit adder and the free slot search, which visits
// one slot per cycle. A tick or clear request walks the slots in order: an
// idle slot is skipped in the read state and an active one goes on to the
// compare state, since the slot RAM read is registered and the shared adder
// then compares times. cmd_stall stays high until a request's last message is
// in the output register. Each note-off is held in a pending register so the
// final one can carry last. When the receiver stalls, the message stays in
// the output register and the walk waits. Reset empties the table at once
// through the per-slot active flags and drops any message in flight; no
// clearing pass is needed.
`default_nettype none
`include "midi_note_off_scheduler_assert.svh"
module midi_note_off_scheduler
    import mnos_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  tx_mask,
    input  wire logic [3:0]  channel,
    input  wire logic [6:0]  note,
    input  wire logic [6:0]  velocity,
    input  wire logic [31:0] length_ms,
    input  wire logic [63:0] now_us,
    output logic             msg_valid,
    input  wire logic        msg_stall,
    output logic [7:0]       out_transport,
    output logic [3:0]       code_index,
    output logic [7:0]       status_byte,
    output logic [6:0]       out_note,
    output logic [6:0]       out_velocity,
    output logic             accepted,
    output logic             last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SLOTS-1:0]  active_reg, active_next;
    logic              pend_valid_reg, pend_valid_next;
    msg_t              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    msg_t              out_reg, out_next;
    logic              out_last_reg, out_last_next;

    logic [1:0]        cmd_reg;
    logic [7:0]        trans_reg;
    logic [3:0]        chan_reg;
    logic [6:0]        note_reg;
    logic [6:0]        vel_reg;
    logic [MS_W-1:0]   dur_reg;
    logic [63:0]       now_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [63:0]       off_reg;

    logic              ram_we;
    slot_t             ram_wdata;
    slot_t             ram_rdata;
    logic [$bits(slot_t)-1:0] ram_rbits;

    logic              cmd_take;
    logic              out_busy;
    logic              idx_last;
    logic              use_sub;
    logic [63:0]       alu_b;
    logic [64:0]       alu_sum;
    logic              match;
    logic [CNT_W-1:0]  cnt_inc;
    msg_t              note_on;
    msg_t              off_msg;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign out_busy  = out_valid_reg && msg_stall;
    assign idx_last  = (idx_reg == IW'(SLOTS - 1));
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    // The shared unit adds for the off time and subtracts for the time compare.
    assign use_sub = (state_reg != S_ADD);
    assign alu_b   = use_sub ? ram_rdata.due_us : {{(64 - PROD_W){1'b0}}, prod_reg};
    assign alu_sum = {1'b0, now_reg} + {1'b0, alu_b ^ {64{use_sub}}} + 65'(use_sub);
    assign match   = (cmd_reg == CMD_CLEAR) || alu_sum[64];

    assign ram_rdata = slot_t'(ram_rbits);
    assign ram_wdata = '{transport: trans_reg, channel: chan_reg, note: note_reg,
                         due_us: off_reg};

    assign note_on = '{transport: trans_reg, code: CODE_NOTE_ON,
                       status: STATUS_NOTE_ON | {4'b0, chan_reg}, note: note_reg,
                       velocity: vel_reg, accepted: 1'b0};
    assign off_msg = '{transport: ram_rdata.transport, code: CODE_NOTE_OFF,
                       status: STATUS_NOTE_OFF | {4'b0, ram_rdata.channel},
                       note: ram_rdata.note, velocity: 7'd0, accepted: 1'b0};

    mnos_ram #(
        .WIDTH($bits(slot_t)),
        .DEPTH(SLOTS),
        .AW   (IW)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(idx_reg),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rbits)
    );

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        active_next     = active_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && msg_stall;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                cnt_next = '0;
                if (cmd_take)
                begin
                    unique case (command)
                        CMD_TRIGGER: state_next = S_MUL;
                        CMD_TICK:    state_next = S_RD;
                        CMD_CLEAR:   state_next = S_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_FIND;
            end
            S_FIND:
            begin
                if (!active_reg[idx_reg])
                begin
                    ram_we               = 1'b1;
                    active_next[idx_reg] = 1'b1;
                    pend_next            = note_on;
                    pend_next.accepted   = 1'b1;
                    pend_valid_next      = 1'b1;
                    state_next           = S_FLUSH;
                end
                else if (idx_last)
                begin
                    pend_next       = note_on;
                    pend_valid_next = 1'b1;
                    state_next      = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_RD:
            begin
                if (active_reg[idx_reg])
                begin
                    state_next = S_CMP;
                end
                else if (idx_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_CMP:
            begin
                if (!match || !(pend_valid_reg && out_busy))
                begin
                    if (match)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_next            = off_msg;
                        pend_valid_next      = 1'b1;
                        active_next[idx_reg] = 1'b0;
                        cnt_next             = cnt_inc;
                    end
                    if (idx_last || (match && cnt_inc == CNT_W'(MAX_RESULTS)))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (cmd_take)
        begin
            cmd_reg   <= command;
            trans_reg <= tx_mask;
            chan_reg  <= channel;
            note_reg  <= note;
            vel_reg   <= velocity;
            dur_reg   <= length_ms;
            now_reg   <= now_us;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(dur_reg * US_PER_MS);
        end
        if (state_reg == S_ADD)
        begin
            off_reg <= alu_sum[63:0];
        end
    end

    assign msg_valid     = out_valid_reg;
    assign out_transport = out_reg.transport;
    assign code_index    = out_reg.code;
    assign status_byte   = out_reg.status;
    assign out_note      = out_reg.note;
    assign out_velocity  = out_reg.velocity;
    assign accepted      = out_reg.accepted;
    assign last          = out_last_reg;

    `MNOS_ASSERT_NOW(a_idle_no_pending, clk, rst_n, state_reg == S_IDLE, !pend_valid_reg,
        "A held message remains while the block is idle.")
    `MNOS_ASSERT_NOW(a_cmp_slot_active, clk, rst_n, state_reg == S_CMP, active_reg[idx_reg],
        "The time compare runs on a free slot.")
    `MNOS_ASSERT_NOW(a_cnt_bounded, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(MAX_RESULTS),
        "More note-offs than allowed for one request.")
    `MNOS_ASSERT_NOW(a_off_not_accepted, clk, rst_n,
        msg_valid && code_index == CODE_NOTE_OFF, !accepted,
        "A note-off message carries the accepted flag.")
    `MNOS_ASSERT_NEXT(a_trigger_starts, clk, rst_n,
        cmd_take && command == CMD_TRIGGER, state_reg == S_MUL,
        "A trigger request did not start the off-time multiply.")

endmodule
`default_nettype wire

// File: rtl/core/mnos_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mnos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: test/midi_note_off_scheduler_test.sv
// Self-checking testbench for the MIDI note-off scheduler with a scoreboard and random traffic.
`default_nettype none
module midi_note_off_scheduler_test;
    import mnos_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int SETTLE_CYCLES = 2 * SLOT_COUNT + 10;
    localparam int HOLD_CYCLES = 200;
    localparam int TIMEOUT_NS = 4_000_000;
    localparam int PRINT_LIMIT = 30;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  transport;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] duration;
        logic [63:0] now;
    } note_request_t;

    typedef struct packed {
        msg_t msg;
        logic last;
    } midi_msg_t;

    class note_scoreboard;
        logic      slot_busy[SLOT_COUNT];
        slot_t     slot_data[SLOT_COUNT];
        midi_msg_t pending_msgs[$];
        int        errors;
        int        requests;
        int        notes_on;
        int        refused;
        int        notes_off;

        function new();
            int i;
            for (i = 0; i < SLOT_COUNT; i++)
            begin
                slot_busy[i] = 1'b0;
                slot_data[i] = '0;
            end
            errors = 0;
            requests = 0;
            notes_on = 0;
            refused = 0;
            notes_off = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function int pending();
            return pending_msgs.size();
        endfunction

        task note_request(note_request_t r);
            midi_msg_t m;
            logic [63:0] due_us;
            logic stored;
            int i;
            int n;
            requests++;
            case (r.command)
                CMD_TRIGGER:
                begin
                    due_us = r.now + 64'(r.duration) * 64'(US_PER_MS);
                    stored = 1'b0;
                    for (i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (!slot_busy[i] && !stored)
                        begin
                            slot_busy[i] = 1'b1;
                            slot_data[i].transport = r.transport;
                            slot_data[i].channel = r.channel;
                            slot_data[i].note = r.note;
                            slot_data[i].due_us = due_us;
                            stored = 1'b1;
                        end
                    end
                    m.msg.transport = r.transport;
                    m.msg.code = CODE_NOTE_ON;
                    m.msg.status = STATUS_NOTE_ON | {4'd0, r.channel};
                    m.msg.note = r.note;
                    m.msg.velocity = r.velocity;
                    m.msg.accepted = stored;
                    m.last = 1'b1;
                    pending_msgs.push_back(m);
                    notes_on++;
                    if (!stored)
                        refused++;
                end
                CMD_TICK, CMD_CLEAR:
                begin
                    n = 0;
                    for (i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (slot_busy[i] && n < MAX_RESULTS &&
                            (r.command == CMD_CLEAR || r.now >= slot_data[i].due_us))
                        begin
                            m.msg.transport = slot_data[i].transport;
                            m.msg.code = CODE_NOTE_OFF;
                            m.msg.status = STATUS_NOTE_OFF | {4'd0, slot_data[i].channel};
                            m.msg.note = slot_data[i].note;
                            m.msg.velocity = 7'd0;
                            m.msg.accepted = 1'b0;
                            m.last = 1'b0;
                            pending_msgs.push_back(m);
                            slot_busy[i] = 1'b0;
                            n++;
                        end
                    end
                    if (n > 0)
                        pending_msgs[pending_msgs.size() - 1].last = 1'b1;
                    notes_off += n;
                end
                default:
                begin
                end
            endcase
        endtask

        task check_message(midi_msg_t got);
            midi_msg_t want;
            if (pending_msgs.size() == 0)
            begin
                report($sformatf("message with nothing expected: %p", got));
                return;
            end
            want = pending_msgs.pop_front();
            if (got !== want)
                report($sformatf("got %p, expected %p", got, want));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  command;
    logic [7:0]  tx_mask;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [31:0] length_ms;
    logic [63:0] now_us;
    logic        msg_valid;
    logic        msg_stall;
    logic [7:0]  out_transport;
    logic [3:0]  code_index;
    logic [7:0]  status_byte;
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic        accepted;
    logic        last;

    logic steady;
    logic pressure_go;
    logic hold_off;

    note_scoreboard sb = new();

    midi_note_off_scheduler #(
        .SLOTS(SLOT_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .command(command),
        .tx_mask(tx_mask),
        .channel(channel),
        .note(note),
        .velocity(velocity),
        .length_ms(length_ms),
        .now_us(now_us),
        .msg_valid(msg_valid),
        .msg_stall(msg_stall),
        .out_transport(out_transport),
        .code_index(code_index),
        .status_byte(status_byte),
        .out_note(out_note),
        .out_velocity(out_velocity),
        .accepted(accepted),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[midi_note_off_scheduler] ERROR");
        $finish;
    end

    initial
    begin
        msg_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            msg_stall <= hold_off || (!steady && $urandom_range(0, 99) < 24);
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && msg_valid && !msg_stall)
            sb.check_message({out_transport, code_index, status_byte, out_note,
                              out_velocity, accepted, last});
    end

    function automatic note_request_t make_request(logic [1:0] cmd, logic [7:0] tm,
                                                   logic [3:0] ch, logic [6:0] nt,
                                                   logic [6:0] vel, logic [31:0] dur,
                                                   logic [63:0] now);
        note_request_t r;
        r.command = cmd;
        r.transport = tm;
        r.channel = ch;
        r.note = nt;
        r.velocity = vel;
        r.duration = dur;
        r.now = now;
        return r;
    endfunction

    task automatic send_request(input note_request_t r);
        if (!steady && $urandom_range(0, 99) < 24)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command <= r.command;
        tx_mask <= r.transport;
        channel <= r.channel;
        note <= r.note;
        velocity <= r.velocity;
        length_ms <= r.duration;
        now_us <= r.now;
        do @(posedge clk); while (cmd_stall);
        sb.note_request(r);
    endtask

    initial
    begin
        int counted;
        int pick;
        int burst;
        int i;
        note_request_t r;
        logic [63:0] clock_us;

        rst_n = 1'b0;
        cmd_valid = 1'b0;
        command = CMD_TRIGGER;
        tx_mask = '0;
        channel = '0;
        note = '0;
        velocity = '0;
        length_ms = '0;
        now_us = '0;
        steady = 1'b0;
        pressure_go = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(CMD_TRIGGER, '1, '1, '1, '1, '1, '1));
        send_request(make_request(CMD_TRIGGER, '0, '0, '0, '0, '0, '0));
        send_request(make_request(CMD_UNUSED, '1, '1, '1, '1, '1, '1));
        send_request(make_request(CMD_TICK, '0, '0, '0, '0, '0, '0));
        send_request(make_request(CMD_TICK, '0, '0, '0, '0, '0, '0));
        send_request(make_request(CMD_TICK, '1, '1, '1, '1, '1, '1));
        for (i = 0; i <= SLOT_COUNT; i++)
            send_request(make_request(CMD_TRIGGER, 8'(i * 13), 4'(i), 7'(i * 7),
                                      7'(127 - i), 32'(i), 64'd1000));
        send_request(make_request(CMD_TICK, '0, '0, '0, '0, '0, 64'd9000));
        send_request(make_request(CMD_CLEAR, '0, '0, '0, '0, '0, '0));
        send_request(make_request(CMD_CLEAR, '1, '1, '1, '1, '1, '1));

        counted = 0;
        burst = 0;
        clock_us = '0;
        while (counted < RANDOM_ITEMS)
        begin
            steady <= (counted >= 150 && counted < 230);
            if (counted == 300)
                pressure_go <= 1'b1;
            clock_us += 64'($urandom_range(0, 2500));
            if ($urandom_range(0, 99) < 3)
                clock_us = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            r = make_request(CMD_TRIGGER, 8'($urandom), 4'($urandom), 7'($urandom),
                             7'($urandom), $urandom_range(0, 4), clock_us);
            if (burst > 0 || (pick >= 93 && pick < 95))
            begin
                if (burst == 0)
                    burst = $urandom_range(16, 22);
                burst--;
                r.duration = $urandom_range(100, 200);
            end
            else if (pick < 50)
            begin
                if ($urandom_range(0, 99) < 10)
                    r.duration = $urandom;
                else if ($urandom_range(0, 99) < 20)
                    r.duration = $urandom_range(0, 100);
            end
            else if (pick < 85)
            begin
                r.command = CMD_TICK;
                if ($urandom_range(0, 99) < 5)
                    r.now = {$urandom, $urandom};
            end
            else if (pick < 93)
                r.command = CMD_CLEAR;
            else
                r.command = CMD_UNUSED;
            if (r.command != CMD_UNUSED)
                counted++;
            send_request(r);
        end
        cmd_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d messages never arrived", sb.pending()));

        $display("Run covered %0d requests: %0d note-ons, %0d of them refused on a full table,",
                 sb.requests, sb.notes_on, sb.refused);
        $display("and %0d note-offs, with a long receiver hold-off and time wraparound.",
                 sb.notes_off);
        if (sb.errors == 0)
            $display("[midi_note_off_scheduler] OK");
        else
            $display("[midi_note_off_scheduler] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
